[rtl/tdh_pkg.sv]
// Shared constants, widths and types of the tilt detector.
package tdh_pkg;

    localparam int unsigned FILTER_SCALE = 100;
    localparam int unsigned COS_SCALE    = 1000;

    localparam int unsigned GAIN_W     = 7;
    localparam int unsigned THR_W      = 10;
    localparam int unsigned AXIS_W     = 8;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 10;

    localparam int unsigned ACC_W  = 15;
    localparam int unsigned SQ_W   = 15;
    localparam int unsigned M2_W   = 17;
    localparam int unsigned LHS_W  = 24;
    localparam int unsigned RHS_W  = 26;
    localparam int unsigned STEP_W = 4;

    localparam int unsigned FILT_STEPS = GAIN_W;
    localparam int unsigned DIV_STEPS  = AXIS_W;
    localparam int unsigned SQR_STEPS  = AXIS_W;
    localparam int unsigned CMP_STEPS  = THR_W;

    localparam logic [GAIN_W-1:0] GAIN_MAX    = GAIN_W'(FILTER_SCALE);
    localparam logic [GAIN_W-1:0] GAIN_RESET  = 7'd10;
    localparam logic [THR_W-1:0]  ENTER_RESET = 10'd500;
    localparam logic [THR_W-1:0]  EXIT_RESET  = 10'd671;
    localparam logic [THR_W-1:0]  COS_CONST   = THR_W'(COS_SCALE);
    localparam logic [ACC_W-1:0]  DIV_BASE    =
        ACC_W'(FILTER_SCALE * (2 ** (DIV_STEPS - 1)));

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FILTER_GAIN     = 2'd0,
        REG_ENTER_THRESHOLD = 2'd1,
        REG_EXIT_THRESHOLD  = 2'd2
    } cfg_reg_t;

    typedef logic [AXIS_W-1:0]        raw_t;
    typedef logic signed [AXIS_W-1:0] axis_t;

endpackage

[rtl/tdh_if.sv]
// Valid/ready channels for samples and results of the tilt detector.
interface tdh_sample_if import tdh_pkg::*; ();
    logic valid;
    logic ready;
    raw_t raw_x;
    raw_t raw_y;
    raw_t raw_z;

    modport source (output valid, output raw_x, output raw_y, output raw_z, input ready);
    modport sink   (input valid, input raw_x, input raw_y, input raw_z, output ready);
endinterface

interface tdh_result_if import tdh_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  slanted;
    logic  upside_down;
    axis_t smooth_x;
    axis_t smooth_y;
    axis_t smooth_z;

    modport source (
        output valid, output slanted, output upside_down,
        output smooth_x, output smooth_y, output smooth_z, input ready
    );
    modport sink (
        input valid, input slanted, input upside_down,
        input smooth_x, input smooth_y, input smooth_z, output ready
    );
endinterface

[rtl/tilt_detector_with_hysteresis.sv]
// Tilt detector: serial smoothing filter, squares and hysteresis compare.
//
// Usage:
//   sample: one transfer carries raw_x, raw_y, raw_z (two's complement bytes).
//   result: one transfer per sample with slanted, upside_down and the
//           filtered axes smooth_x, smooth_y, smooth_z.
//   cfg:    cfg_wr_en/cfg_index/cfg_wdata write filter_gain (0),
//           enter_threshold (1) and exit_threshold (2); write only while idle.
// Timing:
//   A sample runs through four bit-serial phases on three axis lanes:
//   filter multiply, divide by 100, square and the threshold products.
//   The result register loads in the done state after the last phase;
//   sample.ready rises again in the same cycle as the result register
//   loads. The step counter and the shift-add multiplier widths set the
//   length of each phase.
// Reset:
//   Filtered axes and the tilt flag clear, registers return to gain 10,
//   enter 500, exit 671, and no result is pending.
// Stall:
//   A waiting result holds in its register; the next sample is still taken
//   and processed, and it waits in the done state until the result moves.
module tilt_detector_with_hysteresis import tdh_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    tdh_sample_if.sink            sample,
    tdh_result_if.source          result
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILT,
        ST_DIV,
        ST_SQR,
        ST_CMP,
        ST_DONE
    } state_t;

    state_t              state_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [GAIN_W-1:0]   gain_reg;
    logic [THR_W-1:0]    enter_reg;
    logic [THR_W-1:0]    exit_reg;
    logic                flag_reg;
    axis_t               avg_reg [3];

    logic signed [ACC_W-1:0] raw_sh_reg [3];
    logic signed [ACC_W-1:0] old_sh_reg [3];
    logic signed [ACC_W-1:0] acc_reg    [3];
    logic [GAIN_W-1:0]       g_sh_reg;
    logic [GAIN_W-1:0]       h_sh_reg;

    logic [ACC_W-1:0]  rem_reg [3];
    logic [AXIS_W-1:0] quo_reg [3];
    logic              neg_reg [3];
    logic [ACC_W-1:0]  dvs_reg;

    logic [SQ_W-1:0]   sqm_sh_reg [3];
    logic [AXIS_W-1:0] sqb_sh_reg [3];
    logic [SQ_W-1:0]   sq_reg     [3];

    logic [LHS_W-1:0]  lhs_reg;
    logic [RHS_W-1:0]  rhs_reg;
    logic [LHS_W-1:0]  z2_sh_reg;
    logic [RHS_W-1:0]  m2_sh_reg;
    logic [THR_W-1:0]  cos_sh_reg;
    logic [THR_W-1:0]  thr_sh_reg;

    logic  out_valid_reg;
    logic  out_slanted_reg;
    logic  out_upside_reg;
    axis_t out_x_reg;
    axis_t out_y_reg;
    axis_t out_z_reg;

    logic signed [ACC_W-1:0] acc_next [3];
    logic [ACC_W-1:0]        mag_next [3];
    logic [ACC_W-1:0]        rem_next [3];
    logic [AXIS_W-1:0]       quo_next [3];
    logic [SQ_W-1:0]         sq_next  [3];
    logic [M2_W-1:0]         m2_sum;
    logic [LHS_W-1:0]        lhs_next;
    logic [RHS_W-1:0]        rhs_next;
    logic                    flag_next;
    logic                    upside;
    logic [GAIN_W-1:0]       g_eff;
    raw_t                    raw_in [3];
    logic                    last_step;

    assign raw_in[0] = sample.raw_x;
    assign raw_in[1] = sample.raw_y;
    assign raw_in[2] = sample.raw_z;

    assign g_eff  = (gain_reg > GAIN_MAX) ? GAIN_MAX : gain_reg;
    assign upside = ~avg_reg[2][AXIS_W-1];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            acc_next[i] = acc_reg[i]
                        + (g_sh_reg[0] ? raw_sh_reg[i] : '0)
                        + (h_sh_reg[0] ? old_sh_reg[i] : '0);
            mag_next[i] = acc_next[i][ACC_W-1] ? (~acc_next[i] + 1'b1) : acc_next[i];
            rem_next[i] = (rem_reg[i] >= dvs_reg) ? (rem_reg[i] - dvs_reg) : rem_reg[i];
            quo_next[i] = {quo_reg[i][AXIS_W-2:0], rem_reg[i] >= dvs_reg};
            sq_next[i]  = sq_reg[i] + (sqb_sh_reg[i][0] ? sqm_sh_reg[i] : '0);
        end
        m2_sum   = M2_W'(sq_next[0]) + M2_W'(sq_next[1]) + M2_W'(sq_next[2]);
        lhs_next = lhs_reg + (cos_sh_reg[0] ? z2_sh_reg : '0);
        rhs_next = rhs_reg + (thr_sh_reg[0] ? m2_sh_reg : '0);
        if (upside)
        begin
            flag_next = 1'b1;
        end
        else if (flag_reg)
        begin
            flag_next = ~(RHS_W'(lhs_next) >= rhs_next);
        end
        else
        begin
            flag_next = RHS_W'(lhs_next) <= rhs_next;
        end
    end

    always_comb
    begin
        case (state_reg)
            ST_FILT: last_step = (step_reg == STEP_W'(FILT_STEPS - 1));
            ST_DIV:  last_step = (step_reg == STEP_W'(DIV_STEPS - 1));
            ST_SQR:  last_step = (step_reg == STEP_W'(SQR_STEPS - 1));
            ST_CMP:  last_step = (step_reg == STEP_W'(CMP_STEPS - 1));
            default: last_step = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= GAIN_RESET;
            enter_reg <= ENTER_RESET;
            exit_reg  <= EXIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_FILTER_GAIN:     gain_reg  <= cfg_wdata[GAIN_W-1:0];
                REG_ENTER_THRESHOLD: enter_reg <= cfg_wdata[THR_W-1:0];
                REG_EXIT_THRESHOLD:  exit_reg  <= cfg_wdata[THR_W-1:0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                avg_reg[i] <= '0;
            end
        end
        else
        begin
            if (state_reg == ST_DONE && (!out_valid_reg || result.ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            step_reg <= (last_step || state_reg == ST_IDLE) ? '0 : step_reg + 1'b1;

            case (state_reg)
                ST_IDLE:
                begin
                    if (sample.valid)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            raw_sh_reg[i] <= ACC_W'(signed'(raw_in[i]));
                            old_sh_reg[i] <= ACC_W'(avg_reg[i]);
                            acc_reg[i]    <= '0;
                        end
                        g_sh_reg  <= g_eff;
                        h_sh_reg  <= GAIN_MAX - g_eff;
                        state_reg <= ST_FILT;
                    end
                end

                ST_FILT:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        acc_reg[i]    <= acc_next[i];
                        raw_sh_reg[i] <= raw_sh_reg[i] <<< 1;
                        old_sh_reg[i] <= old_sh_reg[i] <<< 1;
                    end
                    g_sh_reg <= g_sh_reg >> 1;
                    h_sh_reg <= h_sh_reg >> 1;
                    if (last_step)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            neg_reg[i] <= acc_next[i][ACC_W-1];
                            rem_reg[i] <= mag_next[i];
                            quo_reg[i] <= '0;
                        end
                        dvs_reg   <= DIV_BASE;
                        state_reg <= ST_DIV;
                    end
                end

                ST_DIV:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        rem_reg[i] <= rem_next[i];
                        quo_reg[i] <= quo_next[i];
                    end
                    dvs_reg <= dvs_reg >> 1;
                    if (last_step)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            avg_reg[i]    <= neg_reg[i] ? axis_t'(~quo_next[i] + 1'b1)
                                                        : axis_t'(quo_next[i]);
                            sqm_sh_reg[i] <= SQ_W'(quo_next[i]);
                            sqb_sh_reg[i] <= quo_next[i];
                            sq_reg[i]     <= '0;
                        end
                        state_reg <= ST_SQR;
                    end
                end

                ST_SQR:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        sq_reg[i]     <= sq_next[i];
                        sqm_sh_reg[i] <= sqm_sh_reg[i] << 1;
                        sqb_sh_reg[i] <= sqb_sh_reg[i] >> 1;
                    end
                    if (last_step)
                    begin
                        z2_sh_reg  <= LHS_W'(sq_next[2]);
                        m2_sh_reg  <= RHS_W'(m2_sum);
                        cos_sh_reg <= COS_CONST;
                        thr_sh_reg <= flag_reg ? exit_reg : enter_reg;
                        lhs_reg    <= '0;
                        rhs_reg    <= '0;
                        state_reg  <= ST_CMP;
                    end
                end

                ST_CMP:
                begin
                    lhs_reg    <= lhs_next;
                    rhs_reg    <= rhs_next;
                    z2_sh_reg  <= z2_sh_reg << 1;
                    m2_sh_reg  <= m2_sh_reg << 1;
                    cos_sh_reg <= cos_sh_reg >> 1;
                    thr_sh_reg <= thr_sh_reg >> 1;
                    if (last_step)
                    begin
                        flag_reg  <= flag_next;
                        state_reg <= ST_DONE;
                    end
                end

                ST_DONE:
                begin
                    if (!out_valid_reg || result.ready)
                    begin
                        out_slanted_reg <= flag_reg;
                        out_upside_reg  <= upside;
                        out_x_reg       <= avg_reg[0];
                        out_y_reg       <= avg_reg[1];
                        out_z_reg       <= avg_reg[2];
                        state_reg       <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign sample.ready       = (state_reg == ST_IDLE);
    assign result.valid       = out_valid_reg;
    assign result.slanted     = out_slanted_reg;
    assign result.upside_down = out_upside_reg;
    assign result.smooth_x    = out_x_reg;
    assign result.smooth_y    = out_y_reg;
    assign result.smooth_z    = out_z_reg;

`ifndef SYNTHESIS
    a_upside_forces_slant: assert property (
        @(posedge clk) disable iff (!rst_n)
        result.valid |-> (!result.upside_down || result.slanted)
    ) else $error("upside_down result without slanted");

    a_upside_matches_sign: assert property (
        @(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.upside_down == !result.smooth_z[AXIS_W-1])
    ) else $error("upside_down disagrees with sign of smooth_z");

    a_one_sample_at_a_time: assert property (
        @(posedge clk) disable iff (!rst_n)
        (sample.valid && sample.ready) |=> !sample.ready
    ) else $error("sample taken while busy");
`endif

endmodule
